// ===== rtl/rud_pkg.sv =====
package rud_pkg;

    // operand and result width
    localparam int DATA_WIDTH = 32;

    // word carried down the pipeline
    typedef struct packed {
        logic [DATA_WIDTH-1:0] rem;  // partial remainder
        logic [DATA_WIDTH-1:0] nq;   // dividend bits still to use on top, quotient bits below
        logic [DATA_WIDTH-1:0] div;  // divisor
    } t_rud_word;

endpackage

// ===== rtl/restoring_unsigned_divider.sv =====
// Unsigned restoring divider, fully pipelined: one quotient bit per register
// stage, DATA_WIDTH stages in all. A division is taken on every clock edge
// with start high (busy is always low, since nothing can back up). Its
// quotient and remainder show on o_quotient / o_remainder for exactly one
// cycle with o_done high. Results come out in the order items went in, one
// per cycle at most. The quotient is built by the chain of one-bit
// subtract-and-select stages. Division by zero returns an all-ones quotient
// and the dividend as remainder. The receiver must take o_done results as
// they come; there is no hold-off.
module restoring_unsigned_divider
    import rud_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_quotient,
    output logic [DATA_WIDTH-1:0] o_remainder
);

    // s_valid/s_word[k+1] is the output of stage k; index 0 is the input item
    logic      s_valid [0:DATA_WIDTH];
    t_rud_word s_word  [0:DATA_WIDTH];

    // the pipeline never stalls
    assign busy = 1'b0;

    // entry: remainder cleared, dividend loaded on the shift side
    assign s_valid[0]     = start & ~busy;
    assign s_word[0].rem  = '0;
    assign s_word[0].nq   = i_dividend;
    assign s_word[0].div  = i_divisor;

    // one stage per quotient bit, MSB first
    for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_stage
        rud_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .i_word  (s_word[k]),
            .o_valid (s_valid[k+1]),
            .o_word  (s_word[k+1])
        );
    end

    // after the last step the shift side holds the full quotient
    assign o_done      = s_valid[DATA_WIDTH];
    assign o_quotient  = s_word[DATA_WIDTH].nq;
    assign o_remainder = s_word[DATA_WIDTH].rem;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // every accepted item comes out at the end of the pipeline
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(DATA_WIDTH) o_done)
        else $error("accepted item did not complete on time");

    // no result without a matching accepted item
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, DATA_WIDTH))
        else $error("result with no matching item");

    // remainder is below a nonzero divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (s_word[DATA_WIDTH].div != '0)) |->
            (o_remainder < s_word[DATA_WIDTH].div))
        else $error("remainder not below divisor");

    // divide by zero gives an all-ones quotient
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (s_word[DATA_WIDTH].div == '0)) |-> (o_quotient == '1))
        else $error("divide by zero quotient not all ones");

endmodule

// ===== rtl/rud_stage.sv =====
module rud_stage
    import rud_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_rud_word i_word,
    output logic      o_valid,
    output t_rud_word o_word
);

    logic                  r_valid;
    t_rud_word             r_word;
    t_rud_word             n_word;
    logic [DATA_WIDTH-1:0] shifted;
    logic [DATA_WIDTH+1:0] diff;
    logic                  fit;

    // shift in the next dividend bit, trial subtract on W+2 bits
    always_comb begin
        shifted      = {i_word.rem[DATA_WIDTH-2:0], i_word.nq[DATA_WIDTH-1]};
        diff         = {1'b0, i_word.rem[DATA_WIDTH-1], shifted}
                     - {2'b00, i_word.div};
        fit          = ~diff[DATA_WIDTH+1];
        n_word.rem   = fit ? diff[DATA_WIDTH-1:0] : shifted;
        n_word.nq    = {i_word.nq[DATA_WIDTH-2:0], fit};
        n_word.div   = i_word.div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule
